@@ rtl/core/image_frame_deframer_macros.svh @@
// assertion macros shared by the deframer modules
// expects clk and rst_n (synchronous, active low) in the using scope
`ifndef IMAGE_FRAME_DEFRAMER_MACROS_SVH
`define IMAGE_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define IFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ifd assertion failed");

// next-cycle implication
`define IFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ifd assertion failed");

`endif

@@ rtl/core/ifd_pkg.sv @@
// shared constants for the image frame deframer
// no dependencies
`timescale 1ns / 1ps

package ifd_pkg;

  // default saturation limit of the line and height counters
  localparam int MAX_LINE_DEF = 4095;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // marker bytes: sync prefix 255,0,0 then a tag byte
  localparam logic [7:0] SYNC_HEAD        = 8'd255;
  localparam logic [7:0] SYNC_ZERO        = 8'd0;
  localparam logic [7:0] TAG_FRAME_START  = 8'd175;
  localparam logic [7:0] TAG_LINE_START   = 8'd128;
  localparam logic [7:0] TAG_LINE_END     = 8'd218;
  localparam logic [7:0] TAG_FRAME_END    = 8'd171;

  // window geometry
  localparam int WIN_DEPTH = 4;
  localparam logic [2:0] WIN_FULL = 3'd4;
  localparam logic [1:0] MARKER_TAIL = 2'd3;

  // fixed result field widths
  localparam int PIX_W = 8;
  localparam int DIM_W = 12;
  localparam int LEN_W = 24;

endpackage

@@ rtl/core/ifd_front.sv @@
// front end: byte window, marker detection, frame/line tracking
// depends on ifd_pkg; pushes pixel and frame-done beats into ifd_queue
`timescale 1ns / 1ps

module ifd_front
  import ifd_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF,
  localparam int LW = $clog2(MAX_LINE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [PIX_W-1:0]  in_data_byte,
  output logic              push,
  output logic              push_done,
  output logic [PIX_W-1:0]  push_pixel,
  output logic [LW-1:0]     push_width,
  output logic [LW-1:0]     push_height
);

  localparam logic [LW-1:0] MAX_V = LW'(MAX_LINE);

  logic [PIX_W-1:0] window_r [WIN_DEPTH];
  logic [PIX_W-1:0] window_nxt [WIN_DEPTH];
  logic [2:0]       fill_r, fill_nxt;
  logic [1:0]       skip_r, skip_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic             in_line_r, in_line_nxt;
  logic [LW-1:0]    line_len_r, line_len_nxt;
  logic [LW-1:0]    last_width_r, last_width_nxt;
  logic [LW-1:0]    line_total_r, line_total_nxt;

  logic             accept;
  logic             judge;
  logic             is_tag;
  logic             is_marker;
  logic [PIX_W-1:0] tag;

  function automatic logic [LW-1:0] sat_inc(input logic [LW-1:0] v);
    return (v >= MAX_V) ? MAX_V : v + LW'(1);
  endfunction

  assign accept = in_valid && in_ready;
  assign judge  = (fill_r >= (WIN_FULL - 3'd1));
  assign tag    = in_data_byte;

  always_comb begin
    unique case (tag) inside
      TAG_FRAME_START, TAG_LINE_START, TAG_LINE_END, TAG_FRAME_END: is_tag = 1'b1;
      default: is_tag = 1'b0;
    endcase
  end

  // window after the shift: window_r[1..3] then the new byte
  assign is_marker = judge && (window_r[1] == SYNC_HEAD) && (window_r[2] == SYNC_ZERO) &&
                     (window_r[3] == SYNC_ZERO) && is_tag;

  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      window_nxt[k] = window_r[k];
    end
    fill_nxt       = fill_r;
    skip_nxt       = skip_r;
    in_frame_nxt   = in_frame_r;
    in_line_nxt    = in_line_r;
    line_len_nxt   = line_len_r;
    last_width_nxt = last_width_r;
    line_total_nxt = line_total_r;
    push           = 1'b0;
    push_done      = 1'b0;
    push_pixel     = '0;
    push_width     = '0;
    push_height    = '0;
    if (accept) begin
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
        window_nxt[k] = window_r[k+1];
      end
      window_nxt[WIN_DEPTH-1] = in_data_byte;
      if (fill_r != WIN_FULL) begin
        fill_nxt = fill_r + 3'd1;
      end
      if (judge) begin
        if (is_marker) begin
          skip_nxt = MARKER_TAIL;
          if (tag == TAG_FRAME_START) begin
            in_frame_nxt   = 1'b1;
            in_line_nxt    = 1'b0;
            line_len_nxt   = '0;
            last_width_nxt = '0;
            line_total_nxt = '0;
          end else if (!in_frame_r) begin
            // markers outside a frame are dropped
          end else if (tag == TAG_LINE_START) begin
            in_line_nxt  = 1'b1;
            line_len_nxt = '0;
          end else if (tag == TAG_LINE_END) begin
            line_total_nxt = sat_inc(line_total_r);
            last_width_nxt = line_len_r;
            in_line_nxt    = 1'b0;
            line_len_nxt   = '0;
          end else begin
            push         = 1'b1;
            push_done    = 1'b1;
            push_width   = last_width_r;
            push_height  = line_total_r;
            in_frame_nxt = 1'b0;
            in_line_nxt  = 1'b0;
            line_len_nxt = '0;
          end
        end else if (skip_r != 2'd0) begin
          skip_nxt = skip_r - 2'd1;
        end else if (in_frame_r && in_line_r) begin
          line_len_nxt = sat_inc(line_len_r);
          push         = 1'b1;
          push_pixel   = window_r[1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        window_r[k] <= '0;
      end
      fill_r       <= '0;
      skip_r       <= '0;
      in_frame_r   <= 1'b0;
      in_line_r    <= 1'b0;
      line_len_r   <= '0;
      last_width_r <= '0;
      line_total_r <= '0;
    end else begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        window_r[k] <= window_nxt[k];
      end
      fill_r       <= fill_nxt;
      skip_r       <= skip_nxt;
      in_frame_r   <= in_frame_nxt;
      in_line_r    <= in_line_nxt;
      line_len_r   <= line_len_nxt;
      last_width_r <= last_width_nxt;
      line_total_r <= line_total_nxt;
    end
  end

endmodule

@@ rtl/core/ifd_queue.sv @@
// small fifo between front and back of the deframer
// depends on ifd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "image_frame_deframer_macros.svh"

module ifd_queue
  import ifd_pkg::*;
#(
  parameter int DATA_W = 1,
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // wraps at DEPTH
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `IFD_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `IFD_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + CNT_W'(1))
  `IFD_ASSERT_NEXT(a_data_kept, push && count_r == '0, rd_data == $past(wr_data))

endmodule

@@ rtl/core/ifd_back.sv @@
// back end: takes queued beats, forms the frame length, holds the output register
// depends on ifd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "image_frame_deframer_macros.svh"

module ifd_back
  import ifd_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF,
  localparam int LW = $clog2(MAX_LINE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic              q_done,
  input  logic [PIX_W-1:0]  q_pixel,
  input  logic [LW-1:0]     q_width,
  input  logic [LW-1:0]     q_height,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_frame_done,
  output logic [PIX_W-1:0]  out_pixel_value,
  output logic [DIM_W-1:0]  out_frame_width,
  output logic [DIM_W-1:0]  out_frame_height,
  output logic [LEN_W-1:0]  out_frame_length
);

  logic              valid_r, valid_nxt;
  logic              done_r;
  logic [PIX_W-1:0]  pixel_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [LEN_W-1:0]  length_r;
  logic [2*LW-1:0]   prod;
  logic              pop;

  assign pop     = q_valid && (!valid_r || out_ready);
  assign q_ready = !valid_r || out_ready;
  assign prod    = q_width * q_height;

  always_comb begin
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      done_r   <= q_done;
      pixel_r  <= q_pixel;
      width_r  <= DIM_W'(q_width);
      height_r <= DIM_W'(q_height);
      length_r <= LEN_W'(prod);
    end
  end

  assign out_valid         = valid_r;
  assign out_is_frame_done = done_r;
  assign out_pixel_value   = pixel_r;
  assign out_frame_width   = width_r;
  assign out_frame_height  = height_r;
  assign out_frame_length  = length_r;

  `IFD_ASSERT_IMPL(a_no_pop_on_stall, valid_r && !out_ready, !pop)
  `IFD_ASSERT_IMPL(a_done_no_pixel, valid_r && done_r, pixel_r == '0)
  `IFD_ASSERT_IMPL(a_pixel_no_dims, valid_r && !done_r,
                   width_r == '0 && height_r == '0 && length_r == '0)

endmodule

@@ rtl/core/image_frame_deframer.sv @@
// image frame deframer, top level: front end, beat queue and back end
// a pixel beat is registered in the beat queue, then in the output register
// throughput: one byte per cycle; the front stalls only while the beat queue is full
// pixel bytes appear three bytes late, once the window has moved past them
// reset: synchronous active-low rst_n clears window, counters, queue and output valid
// depends on ifd_pkg, ifd_front, ifd_queue, ifd_back
`timescale 1ns / 1ps

module image_frame_deframer
  import ifd_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input byte channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_data_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_frame_done,
  output logic [PIX_W-1:0]  out_pixel_value,
  output logic [DIM_W-1:0]  out_frame_width,
  output logic [DIM_W-1:0]  out_frame_height,
  output logic [LEN_W-1:0]  out_frame_length
);

  // counter width follows the saturation limit
  localparam int LW      = $clog2(MAX_LINE + 1);
  // queue entry: done flag, pixel byte, width, height
  localparam int ENTRY_W = 1 + PIX_W + 2 * LW;

  logic               f_push;
  logic               f_done;
  logic [PIX_W-1:0]   f_pixel;
  logic [LW-1:0]      f_width;
  logic [LW-1:0]      f_height;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_wr_ready;
  logic               q_rd_valid;
  logic               q_rd_ready;

  // front takes a byte only while the queue has room for a beat
  assign in_ready = q_wr_ready;

  ifd_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .push         (f_push),
    .push_done    (f_done),
    .push_pixel   (f_pixel),
    .push_width   (f_width),
    .push_height  (f_height)
  );

  assign q_wdata = {f_done, f_pixel, f_width, f_height};

  // decouples marker tracking from the output stall
  ifd_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_push),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wdata),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rdata)
  );

  // back end multiplies width by height on its way into the output register
  ifd_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_rd_valid),
    .q_ready           (q_rd_ready),
    .q_done            (q_rdata[ENTRY_W-1]),
    .q_pixel           (q_rdata[ENTRY_W-2 -: PIX_W]),
    .q_width           (q_rdata[2*LW-1 -: LW]),
    .q_height          (q_rdata[LW-1:0]),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_frame_done (out_is_frame_done),
    .out_pixel_value   (out_pixel_value),
    .out_frame_width   (out_frame_width),
    .out_frame_height  (out_frame_height),
    .out_frame_length  (out_frame_length)
  );

endmodule

@@ tb/tb_deframer_pkg.sv @@
// scoreboard for the image frame deframer testbench: byte-level predictor and
// in-order checking of result beats
// depends on ifd_pkg
`timescale 1ns / 1ps

package tb_deframer_pkg;
  import ifd_pkg::*;

  typedef struct packed {
    logic             frame_done;
    logic [PIX_W-1:0] pixel_byte;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [LEN_W-1:0] frame_len;
  } deframe_beat_t;

  class deframe_scoreboard;
    logic [7:0]    window [WIN_DEPTH];
    int unsigned   filled;
    int unsigned   skip_left;
    bit            frame_open;
    bit            line_open;
    int unsigned   run_len;
    int unsigned   width_last;
    int unsigned   lines_seen;
    int unsigned   max_line;
    int unsigned   mismatches;
    deframe_beat_t expected_beats [$];

    function new(int unsigned limit);
      max_line = limit;
      foreach (window[k]) window[k] = '0;
      filled = 0;
      skip_left = 0;
      frame_open = 1'b0;
      line_open = 1'b0;
      run_len = 0;
      width_last = 0;
      lines_seen = 0;
      mismatches = 0;
    endfunction

    function int unsigned bump(int unsigned v);
      return (v >= max_line) ? max_line : v + 1;
    endfunction

    // shift one accepted byte in and queue the beat it causes, if any
    function void note_byte(logic [7:0] b);
      deframe_beat_t beat;
      logic [7:0]    tag;
      for (int k = 0; k < WIN_DEPTH - 1; k++) window[k] = window[k + 1];
      window[WIN_DEPTH - 1] = b;
      if (filled < WIN_DEPTH) filled++;
      if (filled < WIN_DEPTH) return;

      tag = window[WIN_DEPTH - 1];
      if (window[0] == SYNC_HEAD && window[1] == SYNC_ZERO && window[2] == SYNC_ZERO &&
          (tag == TAG_FRAME_START || tag == TAG_LINE_START ||
           tag == TAG_LINE_END || tag == TAG_FRAME_END)) begin
        skip_left = MARKER_TAIL;
        if (tag == TAG_FRAME_START) begin
          frame_open = 1'b1;
          line_open = 1'b0;
          run_len = 0;
          width_last = 0;
          lines_seen = 0;
        end else if (frame_open) begin
          if (tag == TAG_LINE_START) begin
            line_open = 1'b1;
            run_len = 0;
          end else if (tag == TAG_LINE_END) begin
            lines_seen = bump(lines_seen);
            width_last = run_len;
            line_open = 1'b0;
            run_len = 0;
          end else begin
            beat.frame_done = 1'b1;
            beat.pixel_byte = '0;
            beat.width = DIM_W'(width_last);
            beat.height = DIM_W'(lines_seen);
            beat.frame_len = LEN_W'(width_last * lines_seen);
            expected_beats.push_back(beat);
            frame_open = 1'b0;
            line_open = 1'b0;
            run_len = 0;
          end
        end
        return;
      end

      if (skip_left > 0) begin
        skip_left--;
        return;
      end

      if (frame_open && line_open) begin
        run_len = bump(run_len);
        beat.frame_done = 1'b0;
        beat.pixel_byte = window[0];
        beat.width = '0;
        beat.height = '0;
        beat.frame_len = '0;
        expected_beats.push_back(beat);
      end
    endfunction

    function void check_beat(deframe_beat_t got);
      deframe_beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: done=%0d pixel=%0d width=%0d height=%0d len=%0d",
                   got.frame_done, got.pixel_byte, got.width, got.height, got.frame_len);
        return;
      end
      want = expected_beats.pop_front();
      if (got.frame_done !== want.frame_done || got.pixel_byte !== want.pixel_byte ||
          got.width !== want.width || got.height !== want.height ||
          got.frame_len !== want.frame_len) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat mismatch at %0t", $realtime);
          $display("  expected done=%0d pixel=%0d width=%0d height=%0d len=%0d",
                   want.frame_done, want.pixel_byte, want.width, want.height,
                   want.frame_len);
          $display("  actual   done=%0d pixel=%0d width=%0d height=%0d len=%0d",
                   got.frame_done, got.pixel_byte, got.width, got.height, got.frame_len);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
// top-level testbench for image_frame_deframer: drives camera bytes, checks
// pixel and frame summary beats in order against a predictor
// depends on ifd_pkg, tb_deframer_pkg and the deframer rtl
`timescale 1ns / 1ps

module tb_top;
  import ifd_pkg::*;
  import tb_deframer_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver stall to back up the beat queue
  localparam int DRAIN_CYCLES = 20;   // quiet window for stray beats after the last expected one
  localparam int LONG_LINE = 40;      // payload bytes offered during the long stall

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [PIX_W-1:0] in_data_byte;
  logic             out_valid;
  logic             out_ready;
  logic             out_is_frame_done;
  logic [PIX_W-1:0] out_pixel_value;
  logic [DIM_W-1:0] out_frame_width;
  logic [DIM_W-1:0] out_frame_height;
  logic [LEN_W-1:0] out_frame_length;

  // calm: no idling on either side; hold_off: receiver stalls for HOLD_CYCLES
  bit          calm;
  bit          hold_off;
  int unsigned bytes_sent;

  deframe_scoreboard sb = new(MAX_LINE_DEF);

  image_frame_deframer #(
    .MAX_LINE(MAX_LINE_DEF)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_frame_done (out_is_frame_done),
    .out_pixel_value   (out_pixel_value),
    .out_frame_width   (out_frame_width),
    .out_frame_height  (out_frame_height),
    .out_frame_length  (out_frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one byte beat: optional random gap, then hold valid until the handshake
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sync prefix then the tag byte
  task automatic send_marker(input logic [7:0] tag);
    send_byte(SYNC_HEAD);
    send_byte(SYNC_ZERO);
    send_byte(SYNC_ZERO);
    send_byte(tag);
  endtask

  // hand-picked opening: field extremes and the corner cases of the marker logic
  task automatic directed_frames();
    send_marker(TAG_FRAME_START);   // matches on the very beat that fills the window
    send_marker(TAG_LINE_START);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_marker(TAG_LINE_START);    // reopens the line, width count restarts
    send_byte(8'h55);
    send_marker(TAG_LINE_END);      // width 1
    send_marker(TAG_LINE_END);      // no open line: width 0, still a line
    send_marker(TAG_FRAME_END);
    send_marker(TAG_FRAME_END);     // outside a frame: no summary
  endtask

  // junk between frames: loose bytes, stray markers, broken sync prefixes
  task automatic send_noise();
    logic [7:0] tags [4];
    tags = '{TAG_FRAME_START, TAG_LINE_START, TAG_LINE_END, TAG_FRAME_END};
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      1: send_marker(tags[$urandom_range(0, 3)]);
      2: begin
        // full prefix, then a random byte that is mostly not a tag
        send_byte(SYNC_HEAD);
        send_byte(SYNC_ZERO);
        send_byte(SYNC_ZERO);
        send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        // truncated prefix
        send_byte(SYNC_HEAD);
        send_byte(SYNC_ZERO);
        send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // mostly well-formed frames with random payload, some broken structure and noise
  task automatic random_traffic(input int unsigned goal);
    int unsigned first;
    int unsigned lines;
    first = bytes_sent;
    calm = 1'b1;
    while (bytes_sent - first < goal) begin
      // first stretch runs with no idling at all
      if (bytes_sent - first >= 150) calm = 1'b0;
      if ($urandom_range(0, 99) < 80) begin
        send_marker(TAG_FRAME_START);
        lines = $urandom_range(0, 4);
        repeat (lines) begin
          if ($urandom_range(0, 9) != 0) send_marker(TAG_LINE_START);
          repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)));
          // frame restart in the middle of a frame
          if ($urandom_range(0, 19) == 0) send_marker(TAG_FRAME_START);
          if ($urandom_range(0, 9) != 0) send_marker(TAG_LINE_END);
        end
        if ($urandom_range(0, 9) != 0) send_marker(TAG_FRAME_END);
      end else begin
        send_noise();
      end
    end
    calm = 1'b0;
  endtask

  // one long line while the receiver stalls, so the beat queue fills and
  // the input backs up
  task automatic stall_long_line();
    send_marker(TAG_FRAME_START);
    send_marker(TAG_LINE_START);
    hold_off = 1'b1;
    // payload below the sync head value so no marker forms by chance
    repeat (LONG_LINE) send_byte(8'($urandom_range(0, 254)));
    send_marker(TAG_LINE_END);
    send_marker(TAG_FRAME_END);
  endtask

  // receiver: random ready, calm stretches, and one long hold-off
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        out_ready = calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // result monitor: every accepted beat goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_beat(deframe_beat_t'({out_is_frame_done, out_pixel_value, out_frame_width,
                                     out_frame_height, out_frame_length}));
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    bytes_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_frames();
    random_traffic(400);
    stall_long_line();
    in_valid = 1'b0;

    // wait for every expected beat, then a short quiet window for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ifd_pkg.sv
rtl/core/ifd_front.sv
rtl/core/ifd_queue.sv
rtl/core/ifd_back.sv
rtl/core/image_frame_deframer.sv
tb/tb_deframer_pkg.sv
tb/tb_top.sv
